[sv/windowed_moving_average_macros.svh]
// Assertion macros for the windowed moving average block.
// Used by the top level; no other dependencies.
`ifndef WINDOWED_MOVING_AVERAGE_MACROS_SVH
`define WINDOWED_MOVING_AVERAGE_MACROS_SVH

`ifndef SYNTH
`define WMA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define WMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WMA_ASSERT(lbl, clk, rstn, prop, msg)
`define WMA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/wma_pkg.sv]
// Shared types and constants for the windowed moving average block.
// No dependencies.
package wma_pkg;

    localparam int FRAC_BITS = 8;

    typedef struct packed {
        logic busy;
        logic done;
    } wma_div_stat_t;

endpackage

[sv/wma_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wma_pkg for the status struct.
module wma_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start_i,
    input  logic [NUM_W-1:0]     num_i,
    input  logic [DEN_W-1:0]     den_i,
    output logic [NUM_W-1:0]     quot_o,
    output wma_pkg::wma_div_stat_t stat_o
);
    import wma_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    rem_shift;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i && !busy_reg) begin
            num_next  = num_i;
            den_next  = den_i;
            rem_next  = '0;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(rem_shift - {1'b0, den_reg});
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quot_o      = num_reg;
    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;

endmodule

[sv/windowed_moving_average.sv]
// Moving average over the last WINDOW signed samples, mean in Q.8.
// Depends on wma_pkg, wma_div and windowed_moving_average_macros.svh.
//
// Usage:
//   Input beats arrive on s_valid/s_ready with one signed sample in s_sample.
//   Each input beat yields exactly one output beat on m_valid/m_ready carrying
//   m_mean_q8: the mean of all samples so far while fewer than WINDOW have
//   arrived, then of the last WINDOW samples, times 256, truncated toward zero.
//   The sample ring sits in a synchronous single-port memory; the running sum
//   and fill count sit in registers. One beat is in flight at a time.
//   Each beat passes the states READ, UPD, START, DIV and OUT; in DIV the
//   bit-serial divider produces one quotient bit per cycle for a quotient of
//   NUM_W = SAMPLE_BITS + clog2(WINDOW) + 8 bits. A new input beat is taken
//   only once the previous mean has been loaded into the output register.
//   The output register decouples the sides: a new input beat is taken while
//   a finished mean waits for m_ready. A stalled receiver only holds the next
//   result back once the divider has finished it.
//   Reset (aresetn low, synchronous) empties the window: sum, fill count and
//   write pointer go to zero. Ring contents are not cleared; they are read
//   only after the window has filled.
module windowed_moving_average #(
    parameter int WINDOW      = 32,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS+wma_pkg::FRAC_BITS-1:0] m_mean_q8
);
    import wma_pkg::*;

`include "windowed_moving_average_macros.svh"

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int OUT_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int NUM_W  = SUM_W + FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    neg_reg, neg_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        mean_reg, mean_next;

    logic [SAMPLE_BITS-1:0]  ring_mem [WINDOW];
    logic [SAMPLE_BITS-1:0]  rd_data_reg;
    logic                    ring_we;

    logic                    full;
    logic signed [SUM_W-1:0] new_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic [SUM_W-1:0]        sum_abs;
    logic                    div_start;
    logic [NUM_W-1:0]        div_quot;
    logic [OUT_W-1:0]        quot_low;
    wma_div_stat_t           div_stat;

    assign full    = (count_reg == CNT_W'(WINDOW));
    assign new_ext = SUM_W'(signed'(sample_reg));
    assign old_ext = SUM_W'(signed'(rd_data_reg));
    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quot_low = div_quot[OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[slot_reg];
    end

    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        mean_next    = mean_reg;
        ring_we      = 1'b0;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                ring_we = 1'b1;
                if (full) begin
                    sum_next = sum_reg + new_ext - old_ext;
                end else begin
                    sum_next   = sum_reg + new_ext;
                    count_next = count_reg + 1'b1;
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // load only once the previous beat has left
                if (!m_valid_reg || m_ready) begin
                    mean_next    = neg_reg ? OUT_W'(-quot_low) : quot_low;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg <= sample_next;
        neg_reg    <= neg_next;
        mean_reg   <= mean_next;
    end

    wma_div #(
        .NUM_W(NUM_W),
        .DEN_W(CNT_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start_i(div_start),
        .num_i  ({sum_abs, {FRAC_BITS{1'b0}}}),
        .den_i  (count_reg),
        .quot_o (div_quot),
        .stat_o (div_stat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_mean_q8 = signed'(mean_reg);

    `WMA_ASSERT(a_ready_div_idle, aclk, aresetn, s_ready |-> !div_stat.busy, "divider busy while ready")
    `WMA_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(WINDOW), "fill count past window")
    `WMA_ASSERT(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "second beat taken")
    `WMA_ASSERT(a_done_in_div, aclk, aresetn, div_stat.done |-> (state_reg == ST_DIV), "stray divide done")

endmodule

[bench/windowed_moving_average_test.sv]
// Self-checking bench for windowed_moving_average: drives signed samples, predicts the Q.8 means.
// Depends on wma_pkg and the windowed_moving_average RTL; reads no files.
`timescale 1ns / 1ps

module windowed_moving_average_test;

    localparam int WINDOW        = 32;
    localparam int SAMPLE_BITS   = 8;
    localparam int MEAN_BITS     = SAMPLE_BITS + wma_pkg::FRAC_BITS;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int QUIET_TAIL    = 150;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AFTER    = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 20;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 8'sh7f;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 8'sh80;
    localparam logic signed [MEAN_BITS-1:0]   MEAN_MAX   = 16'sh7f00;
    localparam logic signed [MEAN_BITS-1:0]   MEAN_MIN   = 16'sh8000;

    typedef enum {
        SEG_UNIFORM,
        SEG_TOP_RUN,
        SEG_BOTTOM_RUN,
        SEG_SMALL,
        SEG_SWING,
        SEG_NEAR_EDGE
    } segment_kind_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          known;
        logic signed [MEAN_BITS-1:0]   mean;
    } directed_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_valid  = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample = '0;
    logic                          m_valid;
    logic                          m_ready  = 1'b0;
    logic signed [MEAN_BITS-1:0]   m_mean_q8;

    logic signed [MEAN_BITS-1:0]   pending_means [$];
    logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW];
    int                            window_sum   = 0;
    int                            window_fill  = 0;
    int                            next_slot    = 0;

    int  cycle_count   = 0;
    int  beats_in      = 0;
    int  beats_out     = 0;
    int  mismatches    = 0;
    int  max_hits      = 0;
    int  min_hits      = 0;
    int  full_windows  = 0;
    int  rx_gap        = 0;
    bit  quiet_tail    = 1'b0;
    bit  long_hold     = 1'b0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'sh80, 1'b1, 16'sh8000},
        '{8'sh00, 1'b1, 16'shc000},
        '{8'sh01, 1'b0, 16'sh0000},
        '{8'sh7f, 1'b0, 16'sh0000},
        '{8'sh7f, 1'b0, 16'sh0000},
        '{8'shff, 1'b0, 16'sh0000},
        '{8'shff, 1'b0, 16'sh0000},
        '{8'sh40, 1'b0, 16'sh0000},
        '{8'shc0, 1'b0, 16'sh0000},
        '{8'sh55, 1'b0, 16'sh0000},
        '{8'shaa, 1'b0, 16'sh0000},
        '{8'sh00, 1'b0, 16'sh0000},
        '{8'sh7f, 1'b0, 16'sh0000},
        '{8'sh80, 1'b0, 16'sh0000},
        '{8'sh01, 1'b0, 16'sh0000},
        '{8'shfe, 1'b0, 16'sh0000},
        '{8'sh7e, 1'b0, 16'sh0000},
        '{8'sh81, 1'b0, 16'sh0000},
        '{8'sh0f, 1'b0, 16'sh0000},
        '{8'shf0, 1'b0, 16'sh0000}
    };

    windowed_moving_average #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_mean_q8 (m_mean_q8)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [MEAN_BITS-1:0] advance_window(
        input logic signed [SAMPLE_BITS-1:0] sample
    );
        int scaled;
        if (window_fill >= WINDOW) begin
            window_sum -= window_ring[next_slot];
            full_windows++;
        end else begin
            window_fill++;
        end
        window_sum += sample;
        window_ring[next_slot] = sample;
        next_slot = (next_slot + 1) % WINDOW;
        scaled = window_sum * (1 << wma_pkg::FRAC_BITS);
        return MEAN_BITS'(scaled / window_fill);
    endfunction

    // Offer one sample; call at a falling edge, returns at the falling edge after the sample is taken.
    task automatic push_sample(
        input logic signed [SAMPLE_BITS-1:0] sample,
        input logic                          known,
        input logic signed [MEAN_BITS-1:0]   mean,
        input bit                            may_idle
    );
        logic signed [MEAN_BITS-1:0] predicted;
        int gap;
        if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_window(sample);
        pending_means.push_back(known ? mean : predicted);
        beats_in++;
        @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
        input segment_kind_t kind,
        input int            index
    );
        case (kind)
            SEG_TOP_RUN:    return SAMPLE_MAX;
            SEG_BOTTOM_RUN: return SAMPLE_MIN;
            SEG_SMALL:      return SAMPLE_BITS'($urandom_range(0, 8) - 4);
            SEG_SWING:      return index[0] ? SAMPLE_MAX : SAMPLE_MIN;
            SEG_NEAR_EDGE: begin
                if ($urandom_range(0, 1) == 1) return SAMPLE_BITS'($urandom_range(120, 127));
                return SAMPLE_BITS'(-$urandom_range(121, 128));
            end
            default:        return SAMPLE_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int            sent;
        int            run_len;
        int            pick;
        bit            idle_ok;
        segment_kind_t kind;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            push_sample(directed_rows[i].sample, directed_rows[i].known,
                        directed_rows[i].mean, i > 8);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 11);
            case (pick)
                6:       kind = SEG_TOP_RUN;
                7:       kind = SEG_BOTTOM_RUN;
                8:       kind = SEG_SMALL;
                9:       kind = SEG_SWING;
                10:      kind = SEG_NEAR_EDGE;
                default: kind = SEG_UNIFORM;
            endcase
            if (kind == SEG_TOP_RUN || kind == SEG_BOTTOM_RUN)
                run_len = $urandom_range(WINDOW, WINDOW + 8);
            else
                run_len = $urandom_range(4, 40);
            idle_ok = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                if (sent == RANDOM_ITEMS - QUIET_TAIL)
                    quiet_tail <= 1'b1;
                push_sample(pick_sample(kind, k), 1'b0, '0, idle_ok);
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (pending_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples (%0d directed, %0d random), checked %0d means, %0d mismatches.",
                 beats_in, DIRECTED_ROWS, sent, beats_out, mismatches);
        $display("Full-window means: %0d; top-rail means: %0d; bottom-rail means: %0d.",
                 full_windows, max_hits, min_hits);
        if (mismatches == 0 && pending_means.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hold the result side off long enough for the block to back up into its input.
    initial begin
        while (beats_out < HOLD_AFTER) @(negedge aclk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        long_hold <= 1'b0;
    end

    always @(negedge aclk) begin
        if (long_hold) begin
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            rx_gap  <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        logic signed [MEAN_BITS-1:0] expected;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (pending_means.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected mean beat: %0d", $realtime, m_mean_q8);
            end else begin
                expected = pending_means.pop_front();
                if (m_mean_q8 !== expected) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] mean beat %0d: expected %0d, got %0d",
                                 $realtime, beats_out, expected, m_mean_q8);
                end
                if (expected == MEAN_MAX) max_hits++;
                if (expected == MEAN_MIN) min_hits++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d means outstanding.",
                 cycle_count, pending_means.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
